[design/spsc_pkg.sv]
// Shared constants, types and the quarter-wave sine table for the steering sweep controller.
// Used by spsc_ctrl, spsc_dp and steering_pd_sweep_controller; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
package spsc_pkg;

    localparam int PERIOD_MS        = 10;
    localparam int POLE_FACTOR      = 21;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SWEEP_PERIOD_MS  = 3000;
    localparam int SWEEP_AMPLITUDE  = 1530;

    localparam int POS_W     = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int ERPM_W    = 32;
    localparam int ERR_W     = POS_W + 1;

    localparam int DEPTH_W  = $clog2(SINE_TABLE_DEPTH);
    localparam int QUARTER  = SINE_TABLE_DEPTH / 4;
    localparam int QADDR_W  = DEPTH_W - 1;
    localparam int AMP_W    = $clog2(SWEEP_AMPLITUDE + 1);
    localparam int PHASE_W  = $clog2(SWEEP_PERIOD_MS);
    localparam int SCALED_W = PHASE_W + DEPTH_W;

    // floor(x / SWEEP_PERIOD_MS) ~ (x * RECIP) >> RECIP_SHIFT, off by at most one
    localparam int              RECIP_SHIFT = 32;
    localparam longint unsigned RECIP       = (64'd1 << RECIP_SHIFT) / SWEEP_PERIOD_MS;

    localparam int MUL_W  = 30;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 36;
    localparam int RPM_W  = ACC_W - 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KP_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KD_GAIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KF_MAGNITUDE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FF_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD         = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION     = 3'd7;

    localparam logic [CFG_W-1:0] KP_RESET        = 16'hFD80; // -2.5 in Q8.8
    localparam logic [CFG_W-1:0] KD_RESET        = 16'd0;
    localparam logic [CFG_W-1:0] KF_RESET        = 16'd0;
    localparam logic [CFG_W-1:0] THRESHOLD_RESET = 16'd15;
    localparam logic [CFG_W-1:0] DEADBAND_RESET  = 16'd10;
    localparam logic [CFG_W-1:0] CENTER_RESET    = 16'd1000;
    localparam logic [CFG_W-1:0] HOLD_RESET      = 16'd3460;
    localparam logic [CFG_W-1:0] DURATION_RESET  = 16'd30000;

    // datapath operations
    typedef logic [3:0] t_op;
    localparam t_op OP_NONE = 4'd0;
    localparam t_op OP_IDX  = 4'd1;
    localparam t_op OP_CHK  = 4'd2;
    localparam t_op OP_FIX  = 4'd3;
    localparam t_op OP_ROM  = 4'd4;
    localparam t_op OP_TGT  = 4'd5;
    localparam t_op OP_ERR  = 4'd6;
    localparam t_op OP_KP   = 4'd7;
    localparam t_op OP_KD   = 4'd8;
    localparam t_op OP_SUM  = 4'd9;
    localparam t_op OP_RPM  = 4'd10;
    localparam t_op OP_POLE = 4'd11;

    typedef struct packed {
        logic load;
        logic emit;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic sine_needed;
    } t_sts;

    // quarter-wave sine, Q30 polynomial coefficients
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] SC1     = 64'd1686629713;
    localparam logic [63:0] SC3     = 64'd693598668;
    localparam logic [63:0] SC5     = 64'd85569306;
    localparam logic [63:0] SC7     = 64'd5026995;
    localparam logic [63:0] SC9     = 64'd172272;

    typedef logic [AMP_W-1:0] t_sine_tab [0:QUARTER];

    function automatic t_sine_tab build_sine_tab();
        t_sine_tab   tab;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] p;
        for (int k = 0; k <= QUARTER; k++) begin
            z  = 64'(k) << (32 - DEPTH_W);
            z2 = (z * z) >> 30;
            p  = SC9;
            p  = SC7 - ((p * z2) >> 30);
            p  = SC5 - ((p * z2) >> 30);
            p  = SC3 - ((p * z2) >> 30);
            p  = SC1 - ((p * z2) >> 30);
            p  = (p * z) >> 30;
            if (p > Q30_ONE) begin
                p = Q30_ONE;
            end
            tab[k] = AMP_W'((64'(SWEEP_AMPLITUDE) * p) >> 30);
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine_tab();

endpackage
`default_nettype wire

[design/spsc_ctrl.sv]
// Sequencer for the steering sweep controller: steps the datapath through one item.
// Depends on spsc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spsc_ctrl import spsc_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_accept,
    input  wire  i_out_free,
    input  wire  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_IDX  = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_FIX  = 4'd3;
    localparam logic [3:0] S_ROM  = 4'd4;
    localparam logic [3:0] S_TGT  = 4'd5;
    localparam logic [3:0] S_ERR  = 4'd6;
    localparam logic [3:0] S_KP   = 4'd7;
    localparam logic [3:0] S_KD   = 4'd8;
    localparam logic [3:0] S_SUM  = 4'd9;
    localparam logic [3:0] S_RPM  = 4'd10;
    localparam logic [3:0] S_POLE = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.emit = 1'b0;
        o_cmd.op   = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDX;
                end
            end
            S_IDX: begin
                o_cmd.op = OP_IDX;
                // skip the table lookup when the target is not a sine point
                n_state  = i_sts.sine_needed ? S_CHK : S_ERR;
            end
            S_CHK: begin
                o_cmd.op = OP_CHK;
                n_state  = S_FIX;
            end
            S_FIX: begin
                o_cmd.op = OP_FIX;
                n_state  = S_ROM;
            end
            S_ROM: begin
                o_cmd.op = OP_ROM;
                n_state  = S_TGT;
            end
            S_TGT: begin
                o_cmd.op = OP_TGT;
                n_state  = S_ERR;
            end
            S_ERR: begin
                o_cmd.op = OP_ERR;
                n_state  = S_KP;
            end
            S_KP: begin
                o_cmd.op = OP_KP;
                n_state  = S_KD;
            end
            S_KD: begin
                o_cmd.op = OP_KD;
                n_state  = S_SUM;
            end
            S_SUM: begin
                o_cmd.op = OP_SUM;
                n_state  = S_RPM;
            end
            S_RPM: begin
                o_cmd.op = OP_RPM;
                n_state  = S_POLE;
            end
            S_POLE: begin
                o_cmd.op = OP_POLE;
                n_state  = S_OUT;
            end
            S_OUT: begin
                // hold until the output register can take the beat
                if (i_out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

[design/spsc_dp.sv]
// Datapath of the steering sweep controller: registers, sweep timing, sine lookup,
// shared multiplier and PD law with feedforward, deadband and pole scaling. Depends on spsc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spsc_dp import spsc_pkg::*; (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [CFG_W-1:0]      i_cfg_data,
    input  wire  t_cmd            i_cmd,
    input  wire  [POS_W-1:0]      i_measured_position,
    output t_sts                  o_sts,
    output logic [ERPM_W-1:0]     o_velocity_erpm,
    output logic                  o_set_origin,
    output logic                  o_sweep_status_valid,
    output logic                  o_sweep_done
);

    localparam logic signed [PROD_W-1:0] ERPM_MAX = {{(PROD_W-ERPM_W){1'b0}}, 32'h7FFF_FFFF};
    localparam logic signed [PROD_W-1:0] ERPM_MIN = {{(PROD_W-ERPM_W){1'b1}}, 32'h8000_0000};

    // configuration
    logic [CFG_W-1:0] r_kp;
    logic [CFG_W-1:0] r_kd;
    logic [CFG_W-1:0] r_kf;
    logic [CFG_W-1:0] r_thr;
    logic [CFG_W-1:0] r_db;
    logic [CFG_W-1:0] r_center;
    logic [CFG_W-1:0] r_hold;
    logic [CFG_W-1:0] r_duration;

    // sweep state
    logic               r_mission;
    logic               r_clk_started;
    logic [15:0]        r_elapsed;
    logic [PHASE_W-1:0] r_phase;     // r_elapsed mod SWEEP_PERIOD_MS
    logic [POS_W-1:0]   r_prev;

    logic               n_mission;
    logic               n_clk_started;
    logic [15:0]        n_elapsed;
    logic [PHASE_W-1:0] n_phase;
    logic               n_origin;
    logic               n_valid;
    logic               n_done;
    logic               n_sine;
    logic [POS_W-1:0]   n_target;

    // per-item working registers
    logic                     r_origin;
    logic                     r_valid;
    logic                     r_done;
    logic                     r_sine;
    logic [POS_W-1:0]         r_pos;
    logic [POS_W-1:0]         r_target;
    logic signed [ERR_W-1:0]  r_d;
    logic signed [ERR_W-1:0]  r_e;
    logic signed [PROD_W-1:0] r_prod;
    logic [DEPTH_W-1:0]       r_q;
    logic [DEPTH_W-1:0]       r_idx;
    logic [AMP_W-1:0]         r_mag;
    logic                     r_neg;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [RPM_W-1:0]  r_rpm;

    logic [16:0]              w_elapsed_add;
    logic                     w_elapsed_sat;
    logic [15:0]              w_elapsed_sum;
    logic [PHASE_W-1:0]       w_step;
    logic [PHASE_W:0]         w_phase_add;
    logic [PHASE_W-1:0]       w_phase_sum;
    logic [SCALED_W-1:0]      w_scaled;
    logic [DEPTH_W-1:0]       w_q0;
    logic [SCALED_W-1:0]      w_rem;
    logic [1:0]               w_quad;
    logic [DEPTH_W-3:0]       w_k;
    logic [QADDR_W-1:0]       w_addr;
    logic [POS_W-1:0]         w_mag_ext;
    logic signed [MUL_W-1:0]  w_mul_a;
    logic signed [MUL_W-1:0]  w_mul_b;
    logic signed [PROD_W-1:0] w_prod;
    logic [ERR_W-1:0]         w_abs_e;
    logic signed [ACC_W-1:0]  w_kf_q8;
    logic signed [ACC_W-1:0]  w_ff;
    logic signed [ACC_W-1:0]  w_prod_acc;
    logic [ACC_W-1:0]         w_acc_mag;
    logic [ACC_W-1:0]         w_db_q8;
    logic [RPM_W-1:0]         w_rpm_mag;
    logic signed [RPM_W-1:0]  w_rpm;

    // sweep clock: elapsed saturates, phase follows it modulo the sweep period
    assign w_elapsed_add = {1'b0, r_elapsed} + 17'(PERIOD_MS);
    assign w_elapsed_sat = w_elapsed_add[16];
    assign w_elapsed_sum = w_elapsed_sat ? 16'hFFFF : w_elapsed_add[15:0];
    assign w_step        = w_elapsed_sat ? PHASE_W'(16'hFFFF - r_elapsed) : PHASE_W'(PERIOD_MS);
    assign w_phase_add   = {1'b0, r_phase} + {1'b0, w_step};
    assign w_phase_sum   = (w_phase_add >= (PHASE_W+1)'(SWEEP_PERIOD_MS))
                         ? PHASE_W'(w_phase_add - (PHASE_W+1)'(SWEEP_PERIOD_MS))
                         : w_phase_add[PHASE_W-1:0];

    always_comb begin
        n_mission     = r_mission;
        n_clk_started = r_clk_started;
        n_elapsed     = r_elapsed;
        n_phase       = r_phase;
        n_origin      = 1'b0;
        n_valid       = 1'b0;
        n_done        = 1'b0;
        n_sine        = 1'b0;
        n_target      = r_center;
        priority if (!r_mission) begin
            if (i_measured_position == r_center) begin
                n_mission = 1'b1;
                n_origin  = 1'b1;
            end
        end else if (!r_clk_started) begin
            n_clk_started = 1'b1;
            n_elapsed     = '0;
            n_phase       = '0;
            n_target      = r_hold;
        end else begin
            n_elapsed = w_elapsed_sum;
            n_phase   = w_phase_sum;
            n_valid   = 1'b1;
            if (w_elapsed_sum < r_duration) begin
                n_sine = 1'b1;
            end else begin
                n_target = r_hold;
                n_done   = 1'b1;
            end
        end
    end

    // table index = floor(phase * DEPTH / SWEEP_PERIOD_MS) by reciprocal and one correction
    assign w_scaled = {r_phase, DEPTH_W'(0)};
    assign w_q0     = r_prod[RECIP_SHIFT +: DEPTH_W];
    assign w_rem    = w_scaled - r_prod[SCALED_W-1:0];

    // mirror odd quadrants onto the quarter table
    assign w_quad    = r_idx[DEPTH_W-1 -: 2];
    assign w_k       = r_idx[DEPTH_W-3:0];
    assign w_addr    = w_quad[0] ? (QADDR_W'(QUARTER) - {1'b0, w_k}) : {1'b0, w_k};
    assign w_mag_ext = POS_W'(r_mag);

    // shared multiplier
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (i_cmd.op)
            OP_IDX: begin
                w_mul_a = MUL_W'(w_scaled);
                w_mul_b = MUL_W'(RECIP);
            end
            OP_CHK: begin
                w_mul_a = MUL_W'(w_q0);
                w_mul_b = MUL_W'(SWEEP_PERIOD_MS);
            end
            OP_KP: begin
                w_mul_a = {{(MUL_W-CFG_W){r_kp[CFG_W-1]}}, r_kp};
                w_mul_b = {{(MUL_W-ERR_W){r_e[ERR_W-1]}}, r_e};
            end
            OP_KD: begin
                w_mul_a = {{(MUL_W-CFG_W){r_kd[CFG_W-1]}}, r_kd};
                w_mul_b = {{(MUL_W-ERR_W){r_d[ERR_W-1]}}, r_d};
            end
            OP_POLE: begin
                w_mul_a = {{(MUL_W-RPM_W){r_rpm[RPM_W-1]}}, r_rpm};
                w_mul_b = MUL_W'(POLE_FACTOR);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // feedforward against the error sign, outside the threshold
    assign w_abs_e = r_e[ERR_W-1] ? ERR_W'(-r_e) : ERR_W'(r_e);
    assign w_kf_q8 = {{(ACC_W-CFG_W-8){r_kf[CFG_W-1]}}, r_kf, 8'b0};
    assign w_ff    = (w_abs_e <= {1'b0, r_thr}) ? '0 : (r_e[ERR_W-1] ? w_kf_q8 : -w_kf_q8);

    assign w_prod_acc = r_prod[ACC_W-1:0];

    // deadband, then truncate toward zero
    assign w_acc_mag = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
    assign w_db_q8   = {{(ACC_W-CFG_W-8){1'b0}}, r_db, 8'b0};
    assign w_rpm_mag = w_acc_mag[ACC_W-1:8];
    assign w_rpm     = (w_acc_mag < w_db_q8) ? '0
                     : (r_acc[ACC_W-1] ? -$signed(w_rpm_mag) : $signed(w_rpm_mag));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp          <= KP_RESET;
            r_kd          <= KD_RESET;
            r_kf          <= KF_RESET;
            r_thr         <= THRESHOLD_RESET;
            r_db          <= DEADBAND_RESET;
            r_center      <= CENTER_RESET;
            r_hold        <= HOLD_RESET;
            r_duration    <= DURATION_RESET;
            r_mission     <= 1'b0;
            r_clk_started <= 1'b0;
            r_elapsed     <= '0;
            r_phase       <= '0;
            r_prev        <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_KP_GAIN:      r_kp       <= i_cfg_data;
                    CFG_KD_GAIN:      r_kd       <= i_cfg_data;
                    CFG_KF_MAGNITUDE: r_kf       <= i_cfg_data;
                    CFG_FF_THRESHOLD: r_thr      <= i_cfg_data;
                    CFG_DEADBAND:     r_db       <= i_cfg_data;
                    CFG_CENTER:       r_center   <= i_cfg_data;
                    CFG_HOLD:         r_hold     <= i_cfg_data;
                    CFG_DURATION:     r_duration <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.load) begin
                r_mission     <= n_mission;
                r_clk_started <= n_clk_started;
                r_elapsed     <= n_elapsed;
                r_phase       <= n_phase;
                r_prev        <= i_measured_position;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos    <= i_measured_position;
            r_d      <= $signed({i_measured_position[POS_W-1], i_measured_position})
                      - $signed({r_prev[POS_W-1], r_prev});
            r_target <= n_target;
            r_origin <= n_origin;
            r_valid  <= n_valid;
            r_done   <= n_done;
            r_sine   <= n_sine;
        end
        unique case (i_cmd.op)
            OP_IDX: begin
                r_prod <= w_prod;
            end
            OP_CHK: begin
                r_q    <= w_q0;
                r_prod <= w_prod;
            end
            OP_FIX: begin
                r_idx <= r_q + DEPTH_W'(w_rem >= SCALED_W'(SWEEP_PERIOD_MS));
            end
            OP_ROM: begin
                r_mag <= SINE_TAB[w_addr];
                r_neg <= w_quad[1];
            end
            OP_TGT: begin
                r_target <= r_neg ? (-w_mag_ext) : w_mag_ext;
            end
            OP_ERR: begin
                r_e <= $signed({r_target[POS_W-1], r_target}) - $signed({r_pos[POS_W-1], r_pos});
            end
            OP_KP: begin
                r_prod <= w_prod;
                r_acc  <= w_ff;
            end
            OP_KD: begin
                r_acc  <= r_acc + w_prod_acc;
                r_prod <= w_prod;
            end
            OP_SUM: begin
                r_acc <= r_acc + w_prod_acc;
            end
            OP_RPM: begin
                r_rpm <= w_rpm;
            end
            OP_POLE: begin
                r_prod <= w_prod;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        priority if (r_prod > ERPM_MAX) begin
            o_velocity_erpm = ERPM_MAX[ERPM_W-1:0];
        end else if (r_prod < ERPM_MIN) begin
            o_velocity_erpm = ERPM_MIN[ERPM_W-1:0];
        end else begin
            o_velocity_erpm = r_prod[ERPM_W-1:0];
        end
    end

    assign o_set_origin         = r_origin;
    assign o_sweep_status_valid = r_valid;
    assign o_sweep_done         = r_done;
    assign o_sts.sine_needed    = r_sine;

endmodule
`default_nettype wire

[design/steering_pd_sweep_controller.sv]
// One item at a time: the block takes no new beat until the result of the current one has been
// captured in the output register, so a stalled output register also holds off the input. Each
// item steps through the single shared 30x30 multiplier (index, check, kp, kd, pole) and the sine
// table read; the check, fix, table and target steps are skipped while the target is no sine point.
// Reset (i_rst_n low, synchronous) restores each config register to its listed value and clears
// the sweep state; there is no clearing pass, the block takes a beat in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
module steering_pd_sweep_controller import spsc_pkg::*; (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [CFG_W-1:0]      i_cfg_data,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire  [POS_W-1:0]      i_measured_position,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output logic [ERPM_W-1:0]     o_velocity_erpm,
    output logic                  o_set_origin,
    output logic                  o_sweep_status_valid,
    output logic                  o_sweep_done
);

    t_cmd              w_cmd;
    t_sts              w_sts;
    logic              w_busy;
    logic              w_accept;
    logic              w_out_free;
    logic [ERPM_W-1:0] w_erpm;
    logic              w_origin;
    logic              w_status_valid;
    logic              w_done;

    logic              r_out_valid;
    logic [ERPM_W-1:0] r_erpm;
    logic              r_origin;
    logic              r_status_valid;
    logic              r_done;

    assign w_accept   = i_in_valid & ~w_busy;
    assign w_out_free = ~r_out_valid | ~i_out_stall;

    spsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_out_free (w_out_free),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_busy     (w_busy)
    );

    spsc_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_cmd                (w_cmd),
        .i_measured_position  (i_measured_position),
        .o_sts                (w_sts),
        .o_velocity_erpm      (w_erpm),
        .o_set_origin         (w_origin),
        .o_sweep_status_valid (w_status_valid),
        .o_sweep_done         (w_done)
    );

    // output register: frees the datapath as soon as the result is captured
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.emit) begin
            r_erpm         <= w_erpm;
            r_origin       <= w_origin;
            r_status_valid <= w_status_valid;
            r_done         <= w_done;
        end
    end

    assign o_in_stall           = w_busy;
    assign o_out_valid          = r_out_valid;
    assign o_velocity_erpm      = r_erpm;
    assign o_set_origin         = r_origin;
    assign o_sweep_status_valid = r_status_valid;
    assign o_sweep_done         = r_done;

    a_origin_not_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_set_origin && o_sweep_status_valid))
        else $error("origin pulse reported on a sweep step");

    a_done_needs_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_sweep_done) |-> o_sweep_status_valid)
        else $error("sweep done flagged without a status report");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled while an item is at work");

    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_out_free)
        else $error("result written over an untaken output beat");

endmodule
`default_nettype wire

[dv/spsc_result_checker.sv]
// Scoreboard for the steering sweep controller: watches the register port and both beat channels,
// predicts each result from its own copy of the sweep state and compares in order.
// Depends on spsc_pkg for port widths, register indexes, reset values and block parameters.
`timescale 1ns / 1ps
module spsc_result_checker import spsc_pkg::*; (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire [CFG_IDX_W-1:0] i_cfg_index,
    input  wire [CFG_W-1:0]     i_cfg_data,
    input  wire                 i_in_valid,
    input  wire                 i_in_stall,
    input  wire [POS_W-1:0]     i_measured_position,
    input  wire                 i_out_valid,
    input  wire                 i_out_stall,
    input  wire [ERPM_W-1:0]    i_velocity_erpm,
    input  wire                 i_set_origin,
    input  wire                 i_sweep_status_valid,
    input  wire                 i_sweep_done,
    output int                  o_outstanding,
    output int                  o_fail_count
);

    localparam longint unsigned UNIT_Q30 = 64'd1 << 30;
    localparam longint unsigned TAYLOR_1 = 64'd1686629713;
    localparam longint unsigned TAYLOR_3 = 64'd693598668;
    localparam longint unsigned TAYLOR_5 = 64'd85569306;
    localparam longint unsigned TAYLOR_7 = 64'd5026995;
    localparam longint unsigned TAYLOR_9 = 64'd172272;

    typedef struct packed {
        logic [ERPM_W-1:0] velocity_erpm;
        logic              set_origin;
        logic              status_valid;
        logic              sweep_done;
    } t_drive_command;

    logic [CFG_W-1:0]        cfg_regs [8];
    logic                    centred;
    logic                    sweep_running;
    logic [15:0]             sweep_ms;
    logic signed [POS_W-1:0] last_position;
    t_drive_command          awaited_commands [$];
    int                      fail_n = 0;

    // Table sine of the sweep: quadrant from the phase, odd polynomial on the quarter wave.
    function automatic int sweep_point(input logic [15:0] ms);
        longint unsigned phase, idx, steps, quadrant, offset, z, z2, poly, amp;
        phase    = longint'(ms) % SWEEP_PERIOD_MS;
        idx      = (phase * SINE_TABLE_DEPTH) / SWEEP_PERIOD_MS;
        steps    = idx * 4;
        quadrant = (steps / SINE_TABLE_DEPTH) & 3;
        offset   = steps % SINE_TABLE_DEPTH;
        z        = (offset << 30) / SINE_TABLE_DEPTH;
        if (quadrant[0]) begin
            z = UNIT_Q30 - z;
        end
        z2   = (z * z) >> 30;
        poly = TAYLOR_9;
        poly = TAYLOR_7 - ((poly * z2) >> 30);
        poly = TAYLOR_5 - ((poly * z2) >> 30);
        poly = TAYLOR_3 - ((poly * z2) >> 30);
        poly = TAYLOR_1 - ((poly * z2) >> 30);
        poly = (poly * z) >> 30;
        if (poly > UNIT_Q30) begin
            poly = UNIT_Q30;
        end
        amp = (longint'(SWEEP_AMPLITUDE) * poly) >> 30;
        return quadrant[1] ? -int'(amp) : int'(amp);
    endfunction

    function automatic t_drive_command command_for_position(input logic signed [POS_W-1:0] pos);
        t_drive_command cmd;
        int             target;
        int unsigned    next_ms;
        longint         err, diff, ff_sign, acc, acc_mag, rpm, erpm;
        cmd    = '0;
        target = $signed(cfg_regs[CFG_CENTER]);
        if (!centred) begin
            if (pos == $signed(cfg_regs[CFG_CENTER])) begin
                centred        = 1'b1;
                cmd.set_origin = 1'b1;
            end
        end else if (!sweep_running) begin
            sweep_running = 1'b1;
            sweep_ms      = '0;
            target        = $signed(cfg_regs[CFG_HOLD]);
        end else begin
            // elapsed time sticks at its maximum
            next_ms          = sweep_ms + PERIOD_MS;
            sweep_ms         = (next_ms > 65535) ? 16'hFFFF : next_ms[15:0];
            cmd.status_valid = 1'b1;
            if (sweep_ms < cfg_regs[CFG_DURATION]) begin
                target = sweep_point(sweep_ms);
            end else begin
                target         = $signed(cfg_regs[CFG_HOLD]);
                cmd.sweep_done = 1'b1;
            end
        end

        err           = longint'(target) - longint'(pos);
        diff          = longint'(pos) - longint'(last_position);
        last_position = pos;

        // feedforward pushes against the sign of the error
        if ((err < 0 ? -err : err) <= longint'(cfg_regs[CFG_FF_THRESHOLD])) begin
            ff_sign = 0;
        end else if (err < 0) begin
            ff_sign = 1;
        end else begin
            ff_sign = -1;
        end

        acc = ff_sign * longint'($signed(cfg_regs[CFG_KF_MAGNITUDE])) * 256
            + longint'($signed(cfg_regs[CFG_KP_GAIN])) * err
            + longint'($signed(cfg_regs[CFG_KD_GAIN])) * diff;
        acc_mag = acc < 0 ? -acc : acc;
        if (acc_mag < longint'(cfg_regs[CFG_DEADBAND]) * 256) begin
            rpm = 0;
        end else begin
            rpm = acc < 0 ? -(acc_mag / 256) : acc_mag / 256;
        end

        erpm = rpm * POLE_FACTOR;
        if (erpm > 64'sd2147483647) begin
            erpm = 64'sd2147483647;
        end
        if (erpm < -64'sd2147483648) begin
            erpm = -64'sd2147483648;
        end
        cmd.velocity_erpm = erpm[ERPM_W-1:0];
        return cmd;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            fail_n++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_drive_command want;
        if (!i_rst_n) begin
            cfg_regs[CFG_KP_GAIN]      = KP_RESET;
            cfg_regs[CFG_KD_GAIN]      = KD_RESET;
            cfg_regs[CFG_KF_MAGNITUDE] = KF_RESET;
            cfg_regs[CFG_FF_THRESHOLD] = THRESHOLD_RESET;
            cfg_regs[CFG_DEADBAND]     = DEADBAND_RESET;
            cfg_regs[CFG_CENTER]       = CENTER_RESET;
            cfg_regs[CFG_HOLD]         = HOLD_RESET;
            cfg_regs[CFG_DURATION]     = DURATION_RESET;
            centred       = 1'b0;
            sweep_running = 1'b0;
            sweep_ms      = '0;
            last_position = '0;
            awaited_commands.delete();
        end else begin
            // retire before predicting, so a stray beat never meets a fresh expectation
            if (i_out_valid && !i_out_stall) begin
                if (awaited_commands.size() == 0) begin
                    $display("%0t: unexpected result beat, erpm %0h", $time, i_velocity_erpm);
                    fail_n++;
                end else begin
                    want = awaited_commands.pop_front();
                    check_field("velocity_erpm", want.velocity_erpm, i_velocity_erpm);
                    check_field("set_origin", want.set_origin, i_set_origin);
                    check_field("sweep_status_valid", want.status_valid, i_sweep_status_valid);
                    check_field("sweep_done", want.sweep_done, i_sweep_done);
                end
            end
            if (i_cfg_we) begin
                cfg_regs[i_cfg_index] = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                awaited_commands.push_back(command_for_position($signed(i_measured_position)));
            end
        end
        o_outstanding <= awaited_commands.size();
        o_fail_count  <= fail_n;
    end

endmodule

[dv/steering_pd_sweep_controller_tb.sv]
// Testbench top for steering_pd_sweep_controller: clock, reset, register writes, position beats
// and receiver stalls; checking is left to spsc_result_checker. Depends on spsc_pkg.
`timescale 1ns / 1ps
module steering_pd_sweep_controller_tb import spsc_pkg::*;;

    localparam int CYCLE_LIMIT      = 1000000;
    localparam int LATENCY          = 13;
    localparam int LONG_HOLD        = 300;
    localparam int BEATS_PER_PHASE  = 50;
    localparam int SWEEP_START_BEAT = 15;   // beat that starts the sweep clock
    localparam int HOLD_BEAT        = 560;  // lands early in the no-idle group

    logic                 i_clk               = 1'b0;
    logic                 i_rst_n             = 1'b0;
    logic                 i_cfg_we            = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index         = '0;
    logic [CFG_W-1:0]     i_cfg_data          = '0;
    logic                 i_in_valid          = 1'b0;
    logic [POS_W-1:0]     i_measured_position = '0;
    logic                 i_out_stall         = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [ERPM_W-1:0]    o_velocity_erpm;
    logic                 o_set_origin;
    logic                 o_sweep_status_valid;
    logic                 o_sweep_done;
    int                   pending_results;
    int                   fail_count;

    logic [CFG_W-1:0] reg_values [8];
    logic [POS_W-1:0] last_pos         = '0;
    int               send_idle_pct    = 0;
    int               recv_idle_pct    = 0;
    int               beats_sent       = 0;
    int               cycle_count      = 0;
    int               hold_left        = 0;
    bit               hold_done        = 1'b0;

    steering_pd_sweep_controller dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_measured_position  (i_measured_position),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_velocity_erpm      (o_velocity_erpm),
        .o_set_origin         (o_set_origin),
        .o_sweep_status_valid (o_sweep_status_valid),
        .o_sweep_done         (o_sweep_done)
    );

    spsc_result_checker result_checker (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_in_valid           (i_in_valid),
        .i_in_stall           (o_in_stall),
        .i_measured_position  (i_measured_position),
        .i_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .i_velocity_erpm      (o_velocity_erpm),
        .i_set_origin         (o_set_origin),
        .i_sweep_status_valid (o_sweep_status_valid),
        .i_sweep_done         (o_sweep_done),
        .o_outstanding        (pending_results),
        .o_fail_count         (fail_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off so the block backs up into its input.
    always @(posedge i_clk) begin
        if (!hold_done && beats_sent >= HOLD_BEAT) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    task automatic send_position(input logic [POS_W-1:0] pos);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_measured_position <= pos;
        do @(posedge i_clk); while (o_in_stall);
        beats_sent++;
        last_pos = pos;
    endtask

    // Drop valid and hold until every beat sent so far has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
    endtask

    task automatic write_regs();
        for (int k = 0; k <= CFG_DURATION; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(k);
            i_cfg_data  <= reg_values[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2, 3:    return CFG_W'($urandom());
            default: return CFG_W'($urandom_range(0, 4095) - 2048);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_limit();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return CFG_W'($urandom());
            default: return CFG_W'($urandom_range(0, 64));
        endcase
    endfunction

    // Aim the sweep end near the present sweep time so both running and done steps show up.
    function automatic logic [CFG_W-1:0] pick_duration();
        int sweep_est;
        int span;
        sweep_est = (beats_sent - SWEEP_START_BEAT) * PERIOD_MS;
        span      = sweep_est + int'($urandom_range(0, 1000)) - 300;
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return (span < 0) ? 16'h0000 : (span > 65535) ? 16'hFFFF : CFG_W'(span);
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        case ($urandom_range(0, 7))
            0, 1, 2: return POS_W'($urandom_range(0, 3400) - 1700);
            3:       return POS_W'($urandom());
            4:       return POS_W'(int'($signed(reg_values[CFG_HOLD])) + $urandom_range(0, 40) - 20);
            5:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: return POS_W'(int'($signed(last_pos)) + $urandom_range(0, 64) - 32);
        endcase
    endfunction

    task automatic randomise_regs();
        reg_values[CFG_KP_GAIN]      = pick_gain();
        reg_values[CFG_KD_GAIN]      = pick_gain();
        reg_values[CFG_KF_MAGNITUDE] = pick_gain();
        reg_values[CFG_FF_THRESHOLD] = pick_limit();
        reg_values[CFG_DEADBAND]     = pick_limit();
        reg_values[CFG_CENTER]       = CFG_W'($urandom());
        reg_values[CFG_HOLD]         = $urandom_range(0, 5) == 0 ? pick_gain()
                                     : CFG_W'($urandom_range(0, 8000) - 4000);
        reg_values[CFG_DURATION]     = pick_duration();
    endtask

    initial begin
        reg_values[CFG_KP_GAIN]      = KP_RESET;
        reg_values[CFG_KD_GAIN]      = KD_RESET;
        reg_values[CFG_KF_MAGNITUDE] = KF_RESET;
        reg_values[CFG_FF_THRESHOLD] = THRESHOLD_RESET;
        reg_values[CFG_DEADBAND]     = DEADBAND_RESET;
        reg_values[CFG_CENTER]       = CENTER_RESET;
        reg_values[CFG_HOLD]         = HOLD_RESET;
        reg_values[CFG_DURATION]     = DURATION_RESET;
        send_idle_pct = 27;
        recv_idle_pct = 67;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings, centre not yet reached: extremes and threshold and deadband edges.
        send_position(16'h8000);
        send_position(16'h7FFF);
        send_position(16'h0000);
        send_position(16'hFFFF);
        send_position(16'h5555);
        send_position(16'hAAAA);
        send_position(16'd985);     // error exactly at the feedforward threshold
        send_position(16'd984);
        send_position(16'd1015);
        send_position(16'd1016);
        send_position(16'd996);     // control exactly at the deadband
        send_position(16'd997);     // just inside the deadband
        drain_results();

        // Extreme gains, centre at the bottom of the range, zero sweep length.
        reg_values[CFG_KP_GAIN]      = 16'h7FFF;
        reg_values[CFG_KD_GAIN]      = 16'h8000;
        reg_values[CFG_KF_MAGNITUDE] = 16'h7FFF;
        reg_values[CFG_FF_THRESHOLD] = 16'h0000;
        reg_values[CFG_DEADBAND]     = 16'h0000;
        reg_values[CFG_CENTER]       = 16'h8000;
        reg_values[CFG_HOLD]         = 16'h7FFF;
        reg_values[CFG_DURATION]     = 16'h0000;
        write_regs();
        send_position(16'h7FFF);
        send_position(16'h8000);    // centre match: origin pulse
        send_position(16'h8000);    // sweep start, largest positive error
        send_position(16'h7FFF);    // zero length sweep: done at once
        send_position(16'h8000);
        drain_results();

        // Opposite extremes, longest sweep.
        reg_values[CFG_KP_GAIN]      = 16'h8000;
        reg_values[CFG_KD_GAIN]      = 16'h7FFF;
        reg_values[CFG_KF_MAGNITUDE] = 16'h8000;
        reg_values[CFG_FF_THRESHOLD] = 16'hFFFF;
        reg_values[CFG_DEADBAND]     = 16'hFFFF;
        reg_values[CFG_CENTER]       = 16'h7FFF;
        reg_values[CFG_HOLD]         = 16'h8000;
        reg_values[CFG_DURATION]     = 16'hFFFF;
        write_regs();
        send_position(16'h7FFF);
        send_position(16'h8000);
        send_position(16'h0000);
        send_position(16'd1530);
        send_position(16'hFA06);

        for (int group = 0; group < 3; group++) begin
            case (group)
                0: begin
                    send_idle_pct = 27;
                    recv_idle_pct = 67;
                end
                1: begin
                    send_idle_pct = 67;
                    recv_idle_pct = 27;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int phase = 0; phase < 5; phase++) begin
                drain_results();
                randomise_regs();
                write_regs();
                repeat (BEATS_PER_PHASE) send_position(pick_position());
            end
        end

        drain_results();
        repeat (4 * LATENCY) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
